### src/tofp_pkg.sv
// Shared types and constants for the target offset frame parser.
// Depends on nothing; every other file in src refers to it by scoped names.
package tofp_pkg;

  // counter width for the good frame, error and byte counters
  localparam int CntBits  = 32;
  // register file address width, registers at byte address 4*index
  localparam int AddrBits = 5;

  // highest legal status code in a frame
  localparam logic [7:0] MaxStatus = 8'd3;

  // parser position within the eight byte frame
  typedef enum logic [2:0] {
    PhIdle,
    PhHdr2,
    PhStatus,
    PhXHigh,
    PhXLow,
    PhYHigh,
    PhYLow,
    PhSum
  } phase_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegHeaderFirst,
    RegHeaderSecond,
    RegCenterX,
    RegCenterY,
    RegByteGapLimit,
    RegLinkTimeout
  } reg_idx_e;

  // reset values of the configuration registers
  localparam logic [7:0]  RstHeaderFirst  = 8'hAA;
  localparam logic [7:0]  RstHeaderSecond = 8'h55;
  localparam logic [15:0] RstCenterX      = 16'd160;
  localparam logic [15:0] RstCenterY      = 16'd120;
  localparam logic [15:0] RstByteGapLimit = 16'd50;
  localparam logic [15:0] RstLinkTimeout  = 16'd500;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] byte_gap_limit;
    logic [15:0] link_timeout;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic        frame_done;
    logic [1:0]  track_status;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] good_frames;
    logic [31:0] stamp_ms;
    logic        link_ok;
    logic [31:0] sum_errors;
    logic [31:0] format_errors;
    logic [31:0] byte_total;
  } result_t;

endpackage

### src/target_offset_frame_parser_top.sv
// Top level of the target offset frame parser.
// Depends on tofp_pkg, tofp_apb_regs, tofp_parser and tofp_out_buf.
//
// Takes one item per clock (a received byte or a millisecond tick) while input
// ready is high and gives exactly one result item per input item. All the
// per-item work is a single combinational pass from the parser state to a
// result register; a two-entry output buffer (output register plus skid)
// keeps input ready high while one result waits, so the sustained rate is
// one item per cycle whenever the consumer keeps up. Configuration registers
// sit on an APB-style port at byte address 4*index and should be written
// only while no result is outstanding.
module target_offset_frame_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tofp_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [7:0]                    data_byte_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          frame_done_o,
  output logic [1:0]                    track_status_o,
  output logic signed [15:0]            offset_x_o,
  output logic signed [15:0]            offset_y_o,
  output logic signed [15:0]            pos_x_o,
  output logic signed [15:0]            pos_y_o,
  output logic [31:0]                   good_frames_o,
  output logic [31:0]                   stamp_ms_o,
  output logic                          link_ok_o,
  output logic [31:0]                   sum_errors_o,
  output logic [31:0]                   format_errors_o,
  output logic [31:0]                   byte_total_o
);

  tofp_pkg::cfg_t    cfg;
  tofp_pkg::result_t res_next;
  tofp_pkg::result_t res_out;
  logic              push;

  assign push = in_valid_i & in_ready_o;

  // configuration registers
  tofp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // frame parser and counters
  tofp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .cfg_i       (cfg),
    .res_o       (res_next)
  );

  // result register and skid
  tofp_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_next),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_out)
  );

  // result fields to ports
  assign frame_done_o    = res_out.frame_done;
  assign track_status_o  = res_out.track_status;
  assign offset_x_o      = res_out.offset_x;
  assign offset_y_o      = res_out.offset_y;
  assign pos_x_o         = res_out.pos_x;
  assign pos_y_o         = res_out.pos_y;
  assign good_frames_o   = res_out.good_frames;
  assign stamp_ms_o      = res_out.stamp_ms;
  assign link_ok_o       = res_out.link_ok;
  assign sum_errors_o    = res_out.sum_errors;
  assign format_errors_o = res_out.format_errors;
  assign byte_total_o    = res_out.byte_total;

endmodule

### src/tofp_apb_regs.sv
// APB-style configuration registers for the frame parser.
// Depends on tofp_pkg for the register indexes, reset values and cfg_t.
module tofp_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tofp_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output tofp_pkg::cfg_t               cfg_o
);

  tofp_pkg::cfg_t   cfg_q, cfg_d;
  tofp_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = tofp_pkg::reg_idx_e'(paddr[tofp_pkg::AddrBits-1:2]);
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        tofp_pkg::RegHeaderFirst:  cfg_d.header_first   = pwdata[7:0];
        tofp_pkg::RegHeaderSecond: cfg_d.header_second  = pwdata[7:0];
        tofp_pkg::RegCenterX:      cfg_d.center_x       = pwdata[15:0];
        tofp_pkg::RegCenterY:      cfg_d.center_y       = pwdata[15:0];
        tofp_pkg::RegByteGapLimit: cfg_d.byte_gap_limit = pwdata[15:0];
        tofp_pkg::RegLinkTimeout:  cfg_d.link_timeout   = pwdata[15:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first   <= tofp_pkg::RstHeaderFirst;
      cfg_q.header_second  <= tofp_pkg::RstHeaderSecond;
      cfg_q.center_x       <= tofp_pkg::RstCenterX;
      cfg_q.center_y       <= tofp_pkg::RstCenterY;
      cfg_q.byte_gap_limit <= tofp_pkg::RstByteGapLimit;
      cfg_q.link_timeout   <= tofp_pkg::RstLinkTimeout;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      tofp_pkg::RegHeaderFirst:  prdata = {24'd0, cfg_q.header_first};
      tofp_pkg::RegHeaderSecond: prdata = {24'd0, cfg_q.header_second};
      tofp_pkg::RegCenterX:      prdata = {16'd0, cfg_q.center_x};
      tofp_pkg::RegCenterY:      prdata = {16'd0, cfg_q.center_y};
      tofp_pkg::RegByteGapLimit: prdata = {16'd0, cfg_q.byte_gap_limit};
      tofp_pkg::RegLinkTimeout:  prdata = {16'd0, cfg_q.link_timeout};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/tofp_parser.sv
// Frame parser state, millisecond clock, counters and link flag.
// Depends on tofp_pkg; builds the result item for each accepted input item.
module tofp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              mode_i,
  input  logic [7:0]        data_byte_i,
  input  tofp_pkg::cfg_t    cfg_i,
  output tofp_pkg::result_t res_o
);

  tofp_pkg::phase_e phase_q, phase_d, cur_phase;
  logic [7:0]  held_status_q, held_status_d;
  logic [7:0]  held_xh_q, held_xh_d, held_xl_q, held_xl_d;
  logic [7:0]  held_yh_q, held_yh_d, held_yl_q, held_yl_d;
  logic [31:0] now_q, now_d, last_byte_q, last_byte_d, last_frame_q, last_frame_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] off_x_q, off_x_d, off_y_q, off_y_d;
  logic [tofp_pkg::CntBits-1:0] good_q, good_d, sum_err_q, sum_err_d;
  logic [tofp_pkg::CntBits-1:0] fmt_err_q, fmt_err_d, byte_cnt_q, byte_cnt_d;
  logic        link_q, link_d;
  logic        done;
  logic        stale;
  logic [31:0] now_inc;
  logic [31:0] byte_gap, frame_gap;
  logic [7:0]  sum8;

  // time differences and running checksum of the held frame
  assign now_inc   = now_q + 32'd1;
  assign byte_gap  = now_q - last_byte_q;
  assign frame_gap = now_inc - last_frame_q;
  assign stale     = (phase_q != tofp_pkg::PhIdle) &&
                     (byte_gap > {16'd0, cfg_i.byte_gap_limit});
  assign cur_phase = stale ? tofp_pkg::PhIdle : phase_q;
  assign sum8      = cfg_i.header_first + cfg_i.header_second + held_status_q +
                     held_xh_q + held_xl_q + held_yh_q + held_yl_q;

  // next state for one item
  always_comb begin
    phase_d       = phase_q;
    held_status_d = held_status_q;
    held_xh_d     = held_xh_q;
    held_xl_d     = held_xl_q;
    held_yh_d     = held_yh_q;
    held_yl_d     = held_yl_q;
    now_d         = now_q;
    last_byte_d   = last_byte_q;
    last_frame_d  = last_frame_q;
    status_d      = status_q;
    off_x_d       = off_x_q;
    off_y_d       = off_y_q;
    good_d        = good_q;
    sum_err_d     = sum_err_q;
    fmt_err_d     = fmt_err_q;
    byte_cnt_d    = byte_cnt_q;
    link_d        = link_q;
    done          = 1'b0;
    if (push_i) begin
      if (mode_i) begin
        // millisecond tick
        now_d  = now_inc;
        link_d = (frame_gap > {16'd0, cfg_i.link_timeout}) ? 1'b0 : 1'b1;
      end else begin
        last_byte_d = now_q;
        byte_cnt_d  = byte_cnt_q + 1'b1;
        case (cur_phase)
          tofp_pkg::PhIdle: begin
            if (data_byte_i == cfg_i.header_first) begin
              phase_d = tofp_pkg::PhHdr2;
            end else begin
              phase_d = tofp_pkg::PhIdle;
            end
          end
          tofp_pkg::PhHdr2: begin
            if (data_byte_i == cfg_i.header_second) begin
              phase_d = tofp_pkg::PhStatus;
            end else if (data_byte_i != cfg_i.header_first) begin
              fmt_err_d = fmt_err_q + 1'b1;
              phase_d   = tofp_pkg::PhIdle;
            end else begin
              phase_d = tofp_pkg::PhHdr2;
            end
          end
          tofp_pkg::PhStatus: begin
            held_status_d = data_byte_i;
            phase_d       = tofp_pkg::PhXHigh;
          end
          tofp_pkg::PhXHigh: begin
            held_xh_d = data_byte_i;
            phase_d   = tofp_pkg::PhXLow;
          end
          tofp_pkg::PhXLow: begin
            held_xl_d = data_byte_i;
            phase_d   = tofp_pkg::PhYHigh;
          end
          tofp_pkg::PhYHigh: begin
            held_yh_d = data_byte_i;
            phase_d   = tofp_pkg::PhYLow;
          end
          tofp_pkg::PhYLow: begin
            held_yl_d = data_byte_i;
            phase_d   = tofp_pkg::PhSum;
          end
          default: begin
            // checksum byte closes the frame
            phase_d = tofp_pkg::PhIdle;
            if (sum8 != data_byte_i) begin
              sum_err_d = sum_err_q + 1'b1;
            end else if (held_status_q > tofp_pkg::MaxStatus) begin
              fmt_err_d = fmt_err_q + 1'b1;
            end else begin
              status_d     = held_status_q[1:0];
              off_x_d      = {held_xh_q, held_xl_q};
              off_y_d      = {held_yh_q, held_yl_q};
              good_d       = good_q + 1'b1;
              last_frame_d = now_q;
              link_d       = 1'b1;
              done         = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // control and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tofp_pkg::PhIdle;
      now_q        <= '0;
      last_byte_q  <= '0;
      last_frame_q <= '0;
      status_q     <= '0;
      off_x_q      <= '0;
      off_y_q      <= '0;
      good_q       <= '0;
      sum_err_q    <= '0;
      fmt_err_q    <= '0;
      byte_cnt_q   <= '0;
      link_q       <= 1'b1;
    end else begin
      phase_q      <= phase_d;
      now_q        <= now_d;
      last_byte_q  <= last_byte_d;
      last_frame_q <= last_frame_d;
      status_q     <= status_d;
      off_x_q      <= off_x_d;
      off_y_q      <= off_y_d;
      good_q       <= good_d;
      sum_err_q    <= sum_err_d;
      fmt_err_q    <= fmt_err_d;
      byte_cnt_q   <= byte_cnt_d;
      link_q       <= link_d;
    end
  end

  // held frame bytes, always written before the checksum byte reads them
  always_ff @(posedge clk_i) begin
    held_status_q <= held_status_d;
    held_xh_q     <= held_xh_d;
    held_xl_q     <= held_xl_d;
    held_yh_q     <= held_yh_d;
    held_yl_q     <= held_yl_d;
  end

  // result item reflects the state after this item
  always_comb begin
    res_o.frame_done    = done;
    res_o.track_status  = status_d;
    res_o.offset_x      = off_x_d;
    res_o.offset_y      = off_y_d;
    res_o.pos_x         = cfg_i.center_x + off_x_d;
    res_o.pos_y         = cfg_i.center_y + off_y_d;
    res_o.good_frames   = 32'(good_d);
    res_o.stamp_ms      = last_frame_d;
    res_o.link_ok       = link_d;
    res_o.sum_errors    = 32'(sum_err_d);
    res_o.format_errors = 32'(fmt_err_d);
    res_o.byte_total    = 32'(byte_cnt_d);
  end

`ifndef ASSERT_OFF
  a_done_only_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && done |-> !mode_i)
    else $error("frame completed on a tick item");
  a_link_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && done |=> link_q && (good_q == $past(good_q) + 1'b1))
    else $error("accepted frame did not set link and count");
  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !mode_i |=> byte_cnt_q == $past(byte_cnt_q) + 1'b1)
    else $error("byte counter did not advance");
`endif

endmodule

### src/tofp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on tofp_pkg for result_t.
module tofp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tofp_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output tofp_pkg::result_t data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  tofp_pkg::result_t out_data_q, out_data_d;
  tofp_pkg::result_t skid_data_q, skid_data_d;
  logic              drain;

  assign drain   = out_valid_q & ready_i;
  assign ready_o = ~skid_valid_q;

  // slot steering
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (drain) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || drain) begin
        out_data_d  = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (drain) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && out_valid_q && !ready_i |=> skid_valid_q)
    else $error("item pushed during stall was not parked");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !ready_i |=> out_valid_q && $stable(out_data_q))
    else $error("output item changed while stalled");
`endif

endmodule

### bench/target_offset_frame_parser_top_tb.sv
`timescale 1ns / 1ps
// Testbench for target_offset_frame_parser_top: drives byte and tick items,
// predicts each latched result view and checks every result field.
// Depends on tofp_pkg and the RTL under src; runs stand-alone.
module target_offset_frame_parser_top_tb;
  import tofp_pkg::*;

  typedef enum int {FrGood, FrBadSum, FrBadHeader, FrRepeatHdr} frame_kind_e;

  // clock, reset and block ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrBits-1:0] paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                mode_i      = 1'b0;
  logic [7:0]          data_byte_i = 8'd0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                frame_done_o;
  logic [1:0]          track_status_o;
  logic signed [15:0]  offset_x_o;
  logic signed [15:0]  offset_y_o;
  logic signed [15:0]  pos_x_o;
  logic signed [15:0]  pos_y_o;
  logic [31:0]         good_frames_o;
  logic [31:0]         stamp_ms_o;
  logic                link_ok_o;
  logic [31:0]         sum_errors_o;
  logic [31:0]         format_errors_o;
  logic [31:0]         byte_total_o;

  // shadow of the parser state and its registers
  cfg_t               cfg_shadow;
  phase_e             parse_phase;
  logic [7:0]         held_status, held_xh, held_xl, held_yh, held_yl;
  logic [31:0]        now_ms, last_byte_ms, last_frame_ms;
  logic [1:0]         seen_status;
  logic [15:0]        seen_x, seen_y;
  logic [CntBits-1:0] good_count, sum_fail_count, fmt_fail_count, rx_count;
  logic               link_up;

  // expected views and run bookkeeping
  result_t view_q[$];
  result_t view_want;
  int      errors       = 0;
  int      items_sent   = 0;
  int      views_seen   = 0;
  int      frames_seen  = 0;
  int      reg_writes   = 0;
  bit      sender_gaps  = 1'b1;
  bit      sink_stalls  = 1'b1;
  bit      ticks_in_frames = 1'b0;

  target_offset_frame_parser_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_done_o   (frame_done_o),
    .track_status_o (track_status_o),
    .offset_x_o     (offset_x_o),
    .offset_y_o     (offset_y_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .good_frames_o  (good_frames_o),
    .stamp_ms_o     (stamp_ms_o),
    .link_ok_o      (link_ok_o),
    .sum_errors_o   (sum_errors_o),
    .format_errors_o(format_errors_o),
    .byte_total_o   (byte_total_o)
  );

  always #5 clk_i = ~clk_i;

  // drop any partial frame
  function automatic void clear_held();
    parse_phase = PhIdle;
    held_status = 8'd0;
    held_xh     = 8'd0;
    held_xl     = 8'd0;
    held_yh     = 8'd0;
    held_yl     = 8'd0;
  endfunction

  // advance the shadow parser by one item and return the view it produces
  function automatic result_t predict_view(input logic tick, input logic [7:0] rx);
    result_t     view;
    logic [31:0] elapsed;
    logic [7:0]  sum;
    logic        done;
    done = 1'b0;
    if (tick) begin
      now_ms  = now_ms + 32'd1;
      elapsed = now_ms - last_frame_ms;
      link_up = (elapsed > {16'd0, cfg_shadow.link_timeout}) ? 1'b0 : 1'b1;
    end else begin
      // a partial frame that went quiet too long is dropped first
      elapsed = now_ms - last_byte_ms;
      if (parse_phase != PhIdle && elapsed > {16'd0, cfg_shadow.byte_gap_limit}) begin
        clear_held();
      end
      last_byte_ms = now_ms;
      rx_count     = rx_count + 1'b1;
      case (parse_phase)
        PhIdle: begin
          if (rx == cfg_shadow.header_first) parse_phase = PhHdr2;
        end
        PhHdr2: begin
          // a repeated first header keeps waiting
          if (rx == cfg_shadow.header_second) begin
            parse_phase = PhStatus;
          end else if (rx != cfg_shadow.header_first) begin
            fmt_fail_count = fmt_fail_count + 1'b1;
            clear_held();
          end
        end
        PhStatus: begin
          held_status = rx;
          parse_phase = PhXHigh;
        end
        PhXHigh: begin
          held_xh     = rx;
          parse_phase = PhXLow;
        end
        PhXLow: begin
          held_xl     = rx;
          parse_phase = PhYHigh;
        end
        PhYHigh: begin
          held_yh     = rx;
          parse_phase = PhYLow;
        end
        PhYLow: begin
          held_yl     = rx;
          parse_phase = PhSum;
        end
        default: begin
          // checksum byte: sum first, status range second
          sum = cfg_shadow.header_first + cfg_shadow.header_second + held_status +
                held_xh + held_xl + held_yh + held_yl;
          if (sum != rx) begin
            sum_fail_count = sum_fail_count + 1'b1;
          end else if (held_status > MaxStatus) begin
            fmt_fail_count = fmt_fail_count + 1'b1;
          end else begin
            seen_status   = held_status[1:0];
            seen_x        = {held_xh, held_xl};
            seen_y        = {held_yh, held_yl};
            good_count    = good_count + 1'b1;
            last_frame_ms = now_ms;
            link_up       = 1'b1;
            done          = 1'b1;
          end
          clear_held();
        end
      endcase
    end
    view.frame_done    = done;
    view.track_status  = seen_status;
    view.offset_x      = seen_x;
    view.offset_y      = seen_y;
    view.pos_x         = cfg_shadow.center_x + seen_x;
    view.pos_y         = cfg_shadow.center_y + seen_y;
    view.good_frames   = good_count[31:0];
    view.stamp_ms      = last_frame_ms;
    view.link_ok       = link_up;
    view.sum_errors    = sum_fail_count[31:0];
    view.format_errors = fmt_fail_count[31:0];
    view.byte_total    = rx_count[31:0];
    return view;
  endfunction

  // sink side: random back-pressure unless stalls are off
  always @(posedge clk_i) begin
    out_ready_i <= sink_stalls ? ($urandom_range(99) >= 29) : 1'b1;
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // compare each result with the oldest expected view
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      views_seen++;
      if (frame_done_o === 1'b1) frames_seen++;
      if (view_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got byte_total %0h",
                 $time, byte_total_o);
      end else begin
        view_want = view_q.pop_front();
        check_field("frame_done", view_want.frame_done, frame_done_o);
        check_field("track_status", view_want.track_status, track_status_o);
        check_field("offset_x", view_want.offset_x, $unsigned(offset_x_o));
        check_field("offset_y", view_want.offset_y, $unsigned(offset_y_o));
        check_field("pos_x", view_want.pos_x, $unsigned(pos_x_o));
        check_field("pos_y", view_want.pos_y, $unsigned(pos_y_o));
        check_field("good_frames", view_want.good_frames, good_frames_o);
        check_field("stamp_ms", view_want.stamp_ms, stamp_ms_o);
        check_field("link_ok", view_want.link_ok, link_ok_o);
        check_field("sum_errors", view_want.sum_errors, sum_errors_o);
        check_field("format_errors", view_want.format_errors, format_errors_o);
        check_field("byte_total", view_want.byte_total, byte_total_o);
      end
    end
  end

  // send one item, with random idle cycles ahead of it when sender gaps are on
  task automatic send_item(input logic tick, input logic [7:0] rx);
    if (sender_gaps) begin
      while ($urandom_range(99) < 29) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    mode_i      <= tick;
    data_byte_i <= rx;
    do @(posedge clk_i); while (!in_ready_o);
    view_q.push_back(predict_view(tick, rx));
    items_sent++;
  endtask

  // tick items carry a junk data byte
  task automatic send_tick();
    send_item(1'b1, 8'($urandom()));
  endtask

  // one frame of the given kind, built against the current header values
  task automatic send_frame(input frame_kind_e kind, input logic [7:0] status,
                            input logic [15:0] x, input logic [15:0] y);
    logic [7:0] fb [8];
    int         n;
    fb[0] = cfg_shadow.header_first;
    fb[1] = cfg_shadow.header_second;
    fb[2] = status;
    fb[3] = x[15:8];
    fb[4] = x[7:0];
    fb[5] = y[15:8];
    fb[6] = y[7:0];
    fb[7] = fb[0] + fb[1] + fb[2] + fb[3] + fb[4] + fb[5] + fb[6];
    n = 8;
    if (kind == FrBadSum) fb[7] = fb[7] ^ 8'($urandom_range(1, 255));
    if (kind == FrBadHeader) begin
      n = 2;
      do begin
        fb[1] = 8'($urandom());
      end while (fb[1] == cfg_shadow.header_first || fb[1] == cfg_shadow.header_second);
    end
    if (kind == FrRepeatHdr) send_item(1'b0, fb[0]);
    for (int i = 0; i < n; i++) begin
      // occasional ticks inside a frame exercise the byte gap limit
      if (i > 0 && ticks_in_frames && $urandom_range(99) < 5) begin
        repeat ($urandom_range(1, 3)) send_tick();
      end
      send_item(1'b0, fb[i]);
    end
  endtask

  // stop sending and let every expected result come out
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (view_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write with junk above the register width
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    logic [31:0] wdata;
    wdata = $urandom();
    if (idx == RegHeaderFirst || idx == RegHeaderSecond) wdata[7:0] = value[7:0];
    else wdata[15:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegHeaderFirst:  cfg_shadow.header_first   = wdata[7:0];
      RegHeaderSecond: cfg_shadow.header_second  = wdata[7:0];
      RegCenterX:      cfg_shadow.center_x       = wdata[15:0];
      RegCenterY:      cfg_shadow.center_y       = wdata[15:0];
      RegByteGapLimit: cfg_shadow.byte_gap_limit = wdata[15:0];
      RegLinkTimeout:  cfg_shadow.link_timeout   = wdata[15:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // offsets lean toward the 16-bit extremes
  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // good frame at extreme offsets, bad second header, repeated first header
  // with status above 3, then a checksum mismatch
  task automatic test_frame_cases();
    ticks_in_frames = 1'b0;
    send_frame(FrGood, 8'd3, 16'h8000, 16'h7FFF);
    send_frame(FrBadHeader, 8'd0, 16'h0000, 16'h0000);
    send_frame(FrRepeatHdr, 8'hFF, 16'hFFFF, 16'h0000);
    send_frame(FrBadSum, 8'd1, 16'h0102, 16'h0304);
  endtask

  // a partial frame goes stale, then the link times out
  task automatic test_stale_and_link();
    wait_all_results();
    write_reg(RegByteGapLimit, 16'd1);
    write_reg(RegLinkTimeout, 16'd2);
    send_item(1'b0, cfg_shadow.header_first);
    send_item(1'b0, cfg_shadow.header_second);
    repeat (2) send_tick();
    send_item(1'b0, 8'h00);
    repeat (2) send_tick();
  endtask

  // mostly well-formed frames with random content, plus broken frames,
  // tick bursts and stray bytes, under one register setting
  task automatic test_random_traffic(input int n_items, input bit gaps,
                                     input logic [7:0] hf, input logic [7:0] hs,
                                     input logic [15:0] cx, input logic [15:0] cy,
                                     input logic [15:0] gap, input logic [15:0] tmo);
    int first;
    int pick;
    wait_all_results();
    write_reg(RegHeaderFirst, {8'd0, hf});
    write_reg(RegHeaderSecond, {8'd0, hs});
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegByteGapLimit, gap);
    write_reg(RegLinkTimeout, tmo);
    sender_gaps     = gaps;
    sink_stalls     = gaps;
    ticks_in_frames = 1'b1;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(FrGood, 8'($urandom_range(0, 3)), pick_offset(), pick_offset());
      end else if (pick < 62) begin
        send_frame(FrGood, 8'($urandom_range(4, 255)), pick_offset(), pick_offset());
      end else if (pick < 70) begin
        send_frame(FrBadSum, 8'($urandom()), pick_offset(), pick_offset());
      end else if (pick < 75) begin
        send_frame(FrBadHeader, 8'd0, 16'd0, 16'd0);
      end else if (pick < 82) begin
        send_frame(FrRepeatHdr, 8'($urandom_range(0, 3)), pick_offset(), pick_offset());
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 12)) send_tick();
      end else begin
        repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom()));
      end
    end
  endtask

  // main sequence
  initial begin
    cfg_shadow.header_first   = RstHeaderFirst;
    cfg_shadow.header_second  = RstHeaderSecond;
    cfg_shadow.center_x       = RstCenterX;
    cfg_shadow.center_y       = RstCenterY;
    cfg_shadow.byte_gap_limit = RstByteGapLimit;
    cfg_shadow.link_timeout   = RstLinkTimeout;
    clear_held();
    now_ms         = 32'd0;
    last_byte_ms   = 32'd0;
    last_frame_ms  = 32'd0;
    seen_status    = 2'd0;
    seen_x         = 16'd0;
    seen_y         = 16'd0;
    good_count     = '0;
    sum_fail_count = '0;
    fmt_fail_count = '0;
    rx_count       = '0;
    link_up        = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_cases();
    test_stale_and_link();
    test_random_traffic(100, 1'b1, RstHeaderFirst, RstHeaderSecond, RstCenterX, RstCenterY,
                        RstByteGapLimit, RstLinkTimeout);
    test_random_traffic(100, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'd0, 16'd0);
    test_random_traffic(100, 1'b1, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    test_random_traffic(130, 1'b0, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 40)));
    test_random_traffic(100, 1'b1, 8'($urandom()), 8'($urandom()), 16'h8000, 16'h7FFF,
                        16'd2, 16'd10);
    wait_all_results();

    $display("summary: %0d items sent, %0d results checked, %0d frames accepted",
             items_sent, views_seen, frames_seen);
    $display("summary: %0d register writes over six settings, %0d mismatches",
             reg_writes, errors);
    if (errors == 0) begin
      $display("target_offset_frame_parser_top_tb passed");
    end else begin
      $display("target_offset_frame_parser_top_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("target_offset_frame_parser_top_tb failed");
    $finish;
  end

endmodule
